// ----- design/tautrk_pkg.sv -----
// ----------------------------------------------------------------------------
// tautrk_pkg: shared types and constants of the target angle unwrap tracker
// Holds the sequencer states, the fixed datapath widths and the arctangent
// table of the CORDIC in Q.30 radians.
// ----------------------------------------------------------------------------
package tautrk_pkg;

  localparam int CoordW   = 16;
  localparam int DiffW    = CoordW + 1;
  localparam int InScaleW = 8;
  localparam int XyW      = 28;
  localparam int ZW       = 34;
  localparam int WrapW    = 16;
  localparam int UnwrapW  = 32;
  localparam int DeltaW   = 18;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int AtanLen  = 24;
  localparam int IterCntW = 5;
  localparam int AngleQ   = 30;

  localparam logic [CfgIdxW-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CENTER_Y = 2'd1;

  localparam logic [CoordW-1:0] CENTER_X_RST = 16'd7680;
  localparam logic [CoordW-1:0] CENTER_Y_RST = 16'd5760;

  localparam longint PiQ30     = 64'sd3373259426;
  localparam longint HalfPiQ30 = 64'sd1686629713;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ITER,
    ST_ROUND,
    ST_UNWRAP,
    ST_DONE
  } tautrk_state_e;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [IterCntW-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 34'sd843314857;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043837;
      5'd3:    v = 34'sd133525159;
      5'd4:    v = 34'sd67021687;
      5'd5:    v = 34'sd33543516;
      5'd6:    v = 34'sd16775851;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194283;
      5'd9:    v = 34'sd2097149;
      5'd10:   v = 34'sd1048576;
      5'd11:   v = 34'sd524288;
      5'd12:   v = 34'sd262144;
      5'd13:   v = 34'sd131072;
      5'd14:   v = 34'sd65536;
      5'd15:   v = 34'sd32768;
      5'd16:   v = 34'sd16384;
      5'd17:   v = 34'sd8192;
      5'd18:   v = 34'sd4096;
      5'd19:   v = 34'sd2048;
      5'd20:   v = 34'sd1024;
      5'd21:   v = 34'sd512;
      5'd22:   v = 34'sd256;
      5'd23:   v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/target_angle_unwrap_tracker_core.sv -----
// ----------------------------------------------------------------------------
// An accepted beat steps through the prep, iteration, round, unwrap and done
// states; a new beat is taken only in idle, once the last is done. The single
// shared shift-add CORDIC stage runs once per iteration; a held output beat
// stalls the sequencer in its last state until the output register frees.
// Reset: centers return to 7680/5760, the unwrap history clears, and the
// first beat after reset passes the wrapped angle through.
// ----------------------------------------------------------------------------
// target_angle_unwrap_tracker_core: centroid to atan2 angle with unwrapping
// Forms the offset from the rotation center, runs an iterative vectoring
// CORDIC, rounds and clamps the angle, then accumulates the unwrapped angle.
// ----------------------------------------------------------------------------
module target_angle_unwrap_tracker_core #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int ANGLE_FRAC_BITS   = 13
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tautrk_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tautrk_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tautrk_pkg::CoordW-1:0]     target_x_i,
  input  logic [tautrk_pkg::CoordW-1:0]     target_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tautrk_pkg::WrapW-1:0]   wrapped_angle_o,
  output logic signed [tautrk_pkg::UnwrapW-1:0] unwrapped_angle_o
);
  import tautrk_pkg::*;

  localparam int NumIter  = (CORDIC_ITERATIONS < AtanLen) ? CORDIC_ITERATIONS : AtanLen;
  localparam int RndShift = AngleQ - ANGLE_FRAC_BITS;
  localparam longint RndHalfInt = longint'(1) <<< (RndShift - 1);
  localparam longint PiQInt     = (PiQ30 + RndHalfInt) >>> RndShift;

  localparam logic [IterCntW-1:0] LastIter = IterCntW'(NumIter - 1);
  localparam logic signed [ZW-1:0] RndHalf = ZW'(RndHalfInt);
  localparam logic signed [ZW-1:0] PiQz    = ZW'(PiQInt);
  localparam logic signed [ZW-1:0] HalfPiZ = ZW'(HalfPiQ30);
  localparam logic signed [DeltaW-1:0] PiQd    = DeltaW'(PiQInt);
  localparam logic signed [DeltaW-1:0] TwoPiQd = DeltaW'(2 * PiQInt);
  localparam logic signed [UnwrapW:0] SatMax = {2'b00, {(UnwrapW-1){1'b1}}};
  localparam logic signed [UnwrapW:0] SatMin = {2'b11, {(UnwrapW-1){1'b0}}};

  tautrk_state_e state_q, state_d;

  logic [CoordW-1:0] cx_q, cy_q;
  logic [CoordW-1:0] tx_q, ty_q;
  logic signed [XyW-1:0] x_q, y_q, x_d, y_d;
  logic signed [ZW-1:0]  z_q, z_d;
  logic [IterCntW-1:0]   iter_q;
  logic                  zero_q;
  logic signed [WrapW-1:0]   wrapped_q;
  logic                      has_prev_q;
  logic signed [WrapW-1:0]   last_wrapped_q;
  logic signed [UnwrapW-1:0] last_unwrapped_q;
  logic                      out_valid_q;
  logic signed [WrapW-1:0]   out_wrapped_q;
  logic signed [UnwrapW-1:0] out_unwrapped_q;

  logic in_fire, load_out, iter_last;

  // offset and pre-rotation
  logic signed [DiffW-1:0] dx, dy;
  logic signed [XyW-1:0]   dx_s, dy_s;
  logic signed [XyW-1:0]   x_pre, y_pre;
  logic signed [ZW-1:0]    z_pre;

  assign dx   = $signed({1'b0, tx_q}) - $signed({1'b0, cx_q});
  assign dy   = $signed({1'b0, cy_q}) - $signed({1'b0, ty_q});
  assign dx_s = {{(XyW-DiffW-InScaleW){dx[DiffW-1]}}, dx, {InScaleW{1'b0}}};
  assign dy_s = {{(XyW-DiffW-InScaleW){dy[DiffW-1]}}, dy, {InScaleW{1'b0}}};

  always_comb begin
    if (dx_s[XyW-1]) begin
      if (!dy_s[XyW-1]) begin
        x_pre = dy_s;
        y_pre = -dx_s;
        z_pre = HalfPiZ;
      end else begin
        x_pre = -dy_s;
        y_pre = dx_s;
        z_pre = -HalfPiZ;
      end
    end else begin
      x_pre = dx_s;
      y_pre = dy_s;
      z_pre = '0;
    end
  end

  // shared shift-add stage
  logic signed [XyW-1:0] x_sh, y_sh, x_step, y_step;
  logic signed [ZW-1:0]  z_step, atan_v;
  logic                  y_neg;

  assign x_sh   = x_q >>> iter_q;
  assign y_sh   = y_q >>> iter_q;
  assign atan_v = atan_q30(iter_q);
  assign y_neg  = y_q[XyW-1];
  assign x_step = y_neg ? (x_q - y_sh) : (x_q + y_sh);
  assign y_step = y_neg ? (y_q + x_sh) : (y_q - x_sh);
  assign z_step = y_neg ? (z_q - atan_v) : (z_q + atan_v);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    case (state_q)
      ST_PREP: begin
        x_d = x_pre;
        y_d = y_pre;
        z_d = z_pre;
      end
      ST_ITER: begin
        x_d = x_step;
        y_d = y_step;
        z_d = z_step;
      end
      default: ;
    endcase
  end

  // round and clamp
  logic signed [ZW-1:0]    z_rnd, z_clamp;
  logic signed [WrapW-1:0] wrapped_d;

  assign z_rnd = (z_q + RndHalf) >>> RndShift;

  always_comb begin
    if (z_rnd > PiQz) begin
      z_clamp = PiQz;
    end else if (z_rnd < -PiQz) begin
      z_clamp = -PiQz;
    end else begin
      z_clamp = z_rnd;
    end
    wrapped_d = zero_q ? '0 : z_clamp[WrapW-1:0];
  end

  // unwrap
  logic signed [DeltaW-1:0]  delta0, delta1, delta2;
  logic signed [UnwrapW:0]   sum;
  logic signed [UnwrapW-1:0] unwrapped_d;

  always_comb begin
    delta0 = DeltaW'(wrapped_q) - DeltaW'(last_wrapped_q);
    delta1 = (delta0 > PiQd) ? (delta0 - TwoPiQd) : delta0;
    delta2 = (delta1 < -PiQd) ? (delta1 + TwoPiQd) : delta1;
    sum    = (UnwrapW+1)'(last_unwrapped_q) + (UnwrapW+1)'(delta2);
    if (!has_prev_q) begin
      unwrapped_d = UnwrapW'(wrapped_q);
    end else if (sum > SatMax) begin
      unwrapped_d = SatMax[UnwrapW-1:0];
    end else if (sum < SatMin) begin
      unwrapped_d = SatMin[UnwrapW-1:0];
    end else begin
      unwrapped_d = sum[UnwrapW-1:0];
    end
  end

  assign iter_last = (iter_q == LastIter);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_PREP;
      ST_PREP:   state_d = ST_ITER;
      ST_ITER:   if (iter_last) state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_UNWRAP;
      ST_UNWRAP: state_d = ST_DONE;
      ST_DONE:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_DONE: load_out   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      cx_q             <= CENTER_X_RST;
      cy_q             <= CENTER_Y_RST;
      iter_q           <= '0;
      has_prev_q       <= 1'b0;
      last_wrapped_q   <= '0;
      last_unwrapped_q <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CENTER_X: cx_q <= cfg_data_i;
          REG_CENTER_Y: cy_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_PREP) begin
        iter_q <= '0;
      end else if (state_q == ST_ITER) begin
        iter_q <= iter_q + 1'b1;
      end
      if (state_q == ST_UNWRAP) begin
        has_prev_q       <= 1'b1;
        last_wrapped_q   <= wrapped_q;
        last_unwrapped_q <= unwrapped_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tx_q <= target_x_i;
      ty_q <= target_y_i;
    end
    if (state_q == ST_PREP) begin
      zero_q <= (dx == '0) && (dy == '0);
    end
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    if (state_q == ST_ROUND) begin
      wrapped_q <= wrapped_d;
    end
    if (load_out) begin
      out_wrapped_q   <= last_wrapped_q;
      out_unwrapped_q <= last_unwrapped_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign wrapped_angle_o   = out_wrapped_q;
  assign unwrapped_angle_o = out_unwrapped_q;

  a_hist_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_prev_q |=> has_prev_q)
    else $error("unwrap history lost");

  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_PREP))
    else $error("accepted beat did not start the sequencer");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER) |-> (iter_q <= LastIter))
    else $error("iteration count overran");

  a_wrap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((DeltaW'(wrapped_angle_o) <= PiQd) &&
                     (DeltaW'(wrapped_angle_o) >= -PiQd)))
    else $error("wrapped angle outside of pi range");

endmodule
